FILE: hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define AST_IMPLY(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication, sampled on aclk, off during reset
`define AST_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/hdts_pkg.sv
// shared types and constants of the hopper drain and tare sequencer
package hdts_pkg;

    localparam int WINDOW_DEPTH = 8;
    localparam int SAMPLE_BITS  = 24;
    localparam int TOL_BITS     = 23;
    // compare width: room for the sample, the tolerance and its negation
    localparam int CMP_BITS     = ((SAMPLE_BITS > TOL_BITS) ? SAMPLE_BITS : TOL_BITS) + 2;

    localparam logic signed [SAMPLE_BITS-1:0] WINDOW_INIT   = SAMPLE_BITS'(-1000);
    localparam logic signed [CMP_BITS-1:0]    FLOOR_FILLED  = CMP_BITS'(-200);
    localparam logic [TOL_BITS-1:0]           TOL_RESET     = TOL_BITS'(50);

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_OPENING    = 3'd1,
        PH_WAIT_EMPTY = 3'd2,
        PH_CLOSING    = 3'd3,
        PH_WAIT_TARE  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_STEP
    } ctl_state_t;

    // control from the sequencer to the cell row
    typedef struct packed {
        logic shift_en;
        logic cmp_en;
    } win_ctrl_t;

endpackage

FILE: hw/rtl/hdts_cell.sv
// one window cell: holds a reading, passes it on and judges it against the band
module hdts_cell
    import hdts_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  win_ctrl_t                     ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic [TOL_BITS-1:0]           tolerance,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          ok
);

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          ok_reg;
    logic signed [CMP_BITS-1:0]    r_ext;
    logic signed [CMP_BITS-1:0]    tol_ext;
    logic                          ok_next;

    always_comb begin
        r_ext   = CMP_BITS'(sample_reg);
        tol_ext = $signed({{(CMP_BITS-TOL_BITS){1'b0}}, tolerance});
        ok_next = (r_ext >= FLOOR_FILLED) && (r_ext >= -tol_ext) && (r_ext <= tol_ext);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= WINDOW_INIT;
            ok_reg     <= 1'b0;
        end else begin
            if (ctrl.shift_en) begin
                sample_reg <= sample_in;
            end
            if (ctrl.cmp_en) begin
                ok_reg <= ok_next;
            end
        end
    end

    assign sample_out = sample_reg;
    assign ok         = ok_reg;

endmodule

FILE: hw/rtl/hdts_window.sv
// row of window cells; newest reading enters at the top cell
module hdts_window
    import hdts_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  win_ctrl_t                     ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic [TOL_BITS-1:0]           tolerance,
    output logic                          stable
);

    logic signed [SAMPLE_BITS-1:0] link [WINDOW_DEPTH+1];
    logic [WINDOW_DEPTH-1:0]       ok_vec;

    assign link[WINDOW_DEPTH] = sample_in;

    // oldest reading falls off the bottom of the row
    for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
        hdts_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .sample_in  (link[i+1]),
            .tolerance  (tolerance),
            .sample_out (link[i]),
            .ok         (ok_vec[i])
        );
    end

    assign stable = &ok_vec;

endmodule

FILE: hw/rtl/hopper_drain_and_tare_sequencer.sv
// top level of the hopper drain and tare sequencer
//
// channel  | handshake           | payload
// ---------+---------------------+--------------------------------------------------
// input    | s_valid / s_ready   | s_sample, s_start_finish, s_abort_finish,
//          |                     | s_manual_open, s_manual_close, s_tare_ready,
//          |                     | s_tare_busy
// result   | m_valid / m_ready   | m_valve_open, m_tare_request, m_finishing,
//          |                     | m_phase, m_stable_empty
// config   | tol_wr_en           | tol_wr_data (tolerance, 23 bits)
//
// each word passes through the states in order: accept and shift the cell row,
// register each cell's band check, then the sequencer step loads the result register
// the per-cell compare register sets the latency; s_ready is high in the idle state
// a word may be accepted while the previous result still waits; the step then
// holds until the result register is free
// reset (aresetn low, synchronous) fills the window with -1000, phase idle,
// valve closed, tolerance 50; no clearing pass
module hopper_drain_and_tare_sequencer
    import hdts_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    // config
    input  logic                          tol_wr_en,
    input  logic [TOL_BITS-1:0]           tol_wr_data,
    // input word
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          s_start_finish,
    input  logic                          s_abort_finish,
    input  logic                          s_manual_open,
    input  logic                          s_manual_close,
    input  logic                          s_tare_ready,
    input  logic                          s_tare_busy,
    // result word
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_valve_open,
    output logic                          m_tare_request,
    output logic                          m_finishing,
    output logic [2:0]                    m_phase,
    output logic                          m_stable_empty
);

`include "assert_macros.svh"

    // control and sequence state
    ctl_state_t          state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic                fin_reg, fin_next;
    logic                valve_reg, valve_next;
    logic [TOL_BITS-1:0] tol_reg;

    // flags of the word in flight
    logic start_reg, abort_reg, mopen_reg, mclose_reg, tready_reg, tbusy_reg;

    // result register
    logic   out_valid_reg, out_valid_next;
    logic   out_valve_reg, out_tare_reg, out_fin_reg, out_stable_reg;
    phase_t out_phase_reg;
    logic   load_out;
    logic   tare_req;

    win_ctrl_t win_ctrl;
    logic      stable;
    logic      accept;

    assign accept = s_valid && s_ready;

    hdts_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (win_ctrl),
        .sample_in (s_sample),
        .tolerance (tol_reg),
        .stable    (stable)
    );

    // tolerance register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (tol_wr_en) begin
            tol_reg <= tol_wr_data;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            fin_reg       <= 1'b0;
            valve_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            fin_reg       <= fin_next;
            valve_reg     <= valve_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input flags held for the step
    always_ff @(posedge aclk) begin
        if (accept) begin
            start_reg  <= s_start_finish;
            abort_reg  <= s_abort_finish;
            mopen_reg  <= s_manual_open;
            mclose_reg <= s_manual_close;
            tready_reg <= s_tare_ready;
            tbusy_reg  <= s_tare_busy;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_valve_reg  <= valve_next;
            out_tare_reg   <= tare_req;
            out_fin_reg    <= fin_next;
            out_phase_reg  <= phase_next;
            out_stable_reg <= stable;
        end
    end

    // next state, sequencer step and handshakes
    always_comb begin
        phase_t ph;
        logic   fa;
        logic   vl;

        state_next       = state_reg;
        phase_next       = phase_reg;
        fin_next         = fin_reg;
        valve_next       = valve_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        load_out         = 1'b0;
        tare_req         = 1'b0;
        s_ready          = 1'b0;
        win_ctrl.shift_en = 1'b0;
        win_ctrl.cmp_en   = 1'b0;

        // commands take effect ahead of the step: start, abort, open, close
        ph = phase_reg;
        fa = fin_reg;
        vl = valve_reg;
        if (start_reg && !fa) begin
            fa = 1'b1;
            ph = PH_OPENING;
        end
        if (abort_reg) begin
            fa = 1'b0;
            ph = PH_IDLE;
        end
        if (mopen_reg) begin
            vl = 1'b1;
        end
        if (mclose_reg) begin
            vl = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    win_ctrl.shift_en = 1'b1;
                    state_next        = ST_CMP;
                end
            end
            ST_CMP: begin
                win_ctrl.cmp_en = 1'b1;
                state_next      = ST_STEP;
            end
            ST_STEP: begin
                if (!out_valid_reg || m_ready) begin
                    if (fa) begin
                        case (ph)
                            PH_OPENING: begin
                                vl = 1'b1;
                                ph = PH_WAIT_EMPTY;
                            end
                            PH_WAIT_EMPTY: begin
                                if (stable) begin
                                    ph = PH_CLOSING;
                                end
                            end
                            PH_CLOSING: begin
                                vl       = 1'b0;
                                tare_req = 1'b1;
                                if (tready_reg) begin
                                    ph = PH_WAIT_TARE;
                                end
                            end
                            PH_WAIT_TARE: begin
                                if (!tbusy_reg) begin
                                    fa = 1'b0;
                                    ph = PH_IDLE;
                                end
                            end
                            default: begin
                                // active while idle or an unused code
                                fa = 1'b0;
                                ph = PH_IDLE;
                            end
                        endcase
                    end
                    phase_next     = ph;
                    fin_next       = fa;
                    valve_next     = vl;
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid        = out_valid_reg;
    assign m_valve_open   = out_valve_reg;
    assign m_tare_request = out_tare_reg;
    assign m_finishing    = out_fin_reg;
    assign m_phase        = 3'(out_phase_reg);
    assign m_stable_empty = out_stable_reg;

    // sequence state stays consistent: not finishing means idle
    `AST_IMPLY(a_idle_when_not_fin, !fin_reg, phase_reg == PH_IDLE)
    // a tare request always comes with the valve closed
    `AST_IMPLY(a_tare_valve_shut, out_valid_reg && out_tare_reg, !out_valve_reg)
    // an accepted word always goes on to the band check
    `AST_NEXT(a_accept_to_cmp, accept, state_reg == ST_CMP)
    // a new result only ever comes from the step state
    `AST_IMPLY(a_result_from_step, $rose(out_valid_reg), $past(state_reg) == ST_STEP)

endmodule

FILE: dv/tb_top.sv
// self-checking testbench of the hopper drain and tare sequencer
module tb_top
    import hdts_pkg::*;
();

    // cycles with no word accepted on either channel before the run is declared hung
    localparam int IDLE_LIMIT   = 2000;
    // long receiver hold-off that backs the block up
    localparam int HOLD_CYCLES  = 60;
    // settle time after the last result
    localparam int SETTLE_CYCLES = 12;
    localparam int ITEMS_PER_PHASE = 190;

    // control flag masks of one input word: start, abort, open, close, tare ready, tare busy
    localparam logic [5:0] F_NONE  = 6'b000000;
    localparam logic [5:0] F_START = 6'b100000;
    localparam logic [5:0] F_ABORT = 6'b010000;
    localparam logic [5:0] F_OPEN  = 6'b001000;
    localparam logic [5:0] F_CLOSE = 6'b000100;
    localparam logic [5:0] F_RDY   = 6'b000010;
    localparam logic [5:0] F_BUSY  = 6'b000001;
    localparam logic [5:0] F_ALL   = 6'b111111;

    localparam logic [TOL_BITS-1:0] TOL_MAX = '1;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [5:0]                    flags;
    } tick_t;

    typedef struct {
        logic   valve;
        logic   tare_req;
        logic   active;
        phase_t phase;
        logic   stable;
    } result_t;

    // one row of the directed table; typed rows carry a hand-written result
    typedef struct {
        tick_t   t;
        bit      typed;
        result_t want;
    } row_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // config port
    logic                tol_wr_en   = 1'b0;
    logic [TOL_BITS-1:0] tol_wr_data = '0;

    // input channel
    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample       = '0;
    logic                          s_start_finish = 1'b0;
    logic                          s_abort_finish = 1'b0;
    logic                          s_manual_open  = 1'b0;
    logic                          s_manual_close = 1'b0;
    logic                          s_tare_ready   = 1'b0;
    logic                          s_tare_busy    = 1'b0;

    // result channel
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_valve_open;
    logic       m_tare_request;
    logic       m_finishing;
    logic [2:0] m_phase;
    logic       m_stable_empty;

    // sequencer state as predicted by the testbench
    logic signed [SAMPLE_BITS-1:0] win_model [WINDOW_DEPTH];
    phase_t                        seq_phase;
    logic                          seq_active;
    logic                          valve_state;
    logic [TOL_BITS-1:0]           tol_model;

    // results waiting for their word on the result channel, oldest first
    result_t expected_words [$];
    row_t    directed_rows [$];

    int mismatches     = 0;
    int words_checked  = 0;
    int idle_cycles    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // hold-off request: the sender side bumps hold_seq, the receiver notices the change
    int hold_seq  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    hopper_drain_and_tare_sequencer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .tol_wr_en      (tol_wr_en),
        .tol_wr_data    (tol_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_start_finish (s_start_finish),
        .s_abort_finish (s_abort_finish),
        .s_manual_open  (s_manual_open),
        .s_manual_close (s_manual_close),
        .s_tare_ready   (s_tare_ready),
        .s_tare_busy    (s_tare_busy),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_valve_open   (m_valve_open),
        .m_tare_request (m_tare_request),
        .m_finishing    (m_finishing),
        .m_phase        (m_phase),
        .m_stable_empty (m_stable_empty)
    );

    // 12 unit period
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // one control tick: flags in fixed order, shift the sample in, judge the window,
    // then one step of the finish sequence
    function automatic result_t hopper_step(input tick_t t);
        result_t r;
        longint  v;
        longint  band;
        int      i;
        r.tare_req = 1'b0;
        // start first, abort second so abort wins when both are set
        if ((t.flags & F_START) != 0 && !seq_active) begin
            seq_active = 1'b1;
            seq_phase  = PH_OPENING;
        end
        if ((t.flags & F_ABORT) != 0) begin
            seq_active = 1'b0;
            seq_phase  = PH_IDLE;
        end
        // close after open so close wins
        if ((t.flags & F_OPEN) != 0)
            valve_state = 1'b1;
        if ((t.flags & F_CLOSE) != 0)
            valve_state = 1'b0;
        for (i = 1; i < WINDOW_DEPTH; i++)
            win_model[i-1] = win_model[i];
        win_model[WINDOW_DEPTH-1] = t.sample;
        // full-precision compare, no wrap even for the widest tolerance
        band = longint'(tol_model);
        r.stable = 1'b1;
        for (i = 0; i < WINDOW_DEPTH; i++) begin
            v = longint'(win_model[i]);
            if (v < longint'(FLOOR_FILLED) || v < -band || v > band)
                r.stable = 1'b0;
        end
        if (seq_active) begin
            case (seq_phase)
                PH_OPENING: begin
                    valve_state = 1'b1;
                    seq_phase   = PH_WAIT_EMPTY;
                end
                PH_WAIT_EMPTY: begin
                    if (r.stable)
                        seq_phase = PH_CLOSING;
                end
                PH_CLOSING: begin
                    // request repeats every tick until the tare unit takes it
                    valve_state = 1'b0;
                    r.tare_req  = 1'b1;
                    if ((t.flags & F_RDY) != 0)
                        seq_phase = PH_WAIT_TARE;
                end
                PH_WAIT_TARE: begin
                    if ((t.flags & F_BUSY) == 0) begin
                        seq_active = 1'b0;
                        seq_phase  = PH_IDLE;
                    end
                end
                default: begin
                    seq_active = 1'b0;
                    seq_phase  = PH_IDLE;
                end
            endcase
        end
        r.valve  = valve_state;
        r.active = seq_active;
        r.phase  = seq_phase;
        return r;
    endfunction

    // random tick, mostly quiet samples inside the current band so the
    // sequence gets through to the tare handshake
    function automatic tick_t random_tick();
        tick_t t;
        int    pick;
        int    lo;
        int    hi;
        lo   = (tol_model > 200) ? 200 : int'(tol_model);
        hi   = (tol_model > 400) ? 400 : int'(tol_model);
        pick = $urandom_range(0, 99);
        if (pick < 5)
            t.sample = SAMPLE_BITS'($urandom);
        else if (pick < 12)
            t.sample = SAMPLE_BITS'(int'($urandom_range(0, 1300)) - 1000);
        else if (pick < 22)
            // straddles the band edges and the -200 floor
            t.sample = SAMPLE_BITS'(int'($urandom_range(0, 2 * hi + 4)) - (hi + 2));
        else
            t.sample = SAMPLE_BITS'(int'($urandom_range(0, lo + hi)) - lo);
        t.flags = F_NONE;
        if ($urandom_range(0, 99) < 8)
            t.flags |= F_START;
        if ($urandom_range(0, 99) < 2)
            t.flags |= F_ABORT;
        if ($urandom_range(0, 99) < 3)
            t.flags |= F_OPEN;
        if ($urandom_range(0, 99) < 3)
            t.flags |= F_CLOSE;
        if ($urandom_range(0, 99) < 40)
            t.flags |= F_RDY;
        if ($urandom_range(0, 99) < 55)
            t.flags |= F_BUSY;
        return t;
    endfunction

    task automatic report_mismatch(input string what, input logic [2:0] got,
                                   input logic [2:0] want);
        mismatches++;
        $display("result word %0d: %s is %0d, should be %0d", words_checked, what, got, want);
    endtask

    task automatic row_pred(input logic signed [SAMPLE_BITS-1:0] s, input logic [5:0] f);
        row_t r;
        r.t.sample = s;
        r.t.flags  = f;
        r.typed    = 1'b0;
        directed_rows.push_back(r);
    endtask

    task automatic row_exp(input logic signed [SAMPLE_BITS-1:0] s, input logic [5:0] f,
                           input logic valve, input logic tare_req, input logic active,
                           input phase_t ph, input logic stable);
        row_t r;
        r.t.sample      = s;
        r.t.flags       = f;
        r.typed         = 1'b1;
        r.want.valve    = valve;
        r.want.tare_req = tare_req;
        r.want.active   = active;
        r.want.phase    = ph;
        r.want.stable   = stable;
        directed_rows.push_back(r);
    endtask

    // offer one word, hold it until taken, then queue its expected result
    task automatic send_tick(input tick_t t, input bit typed, input result_t want);
        result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample       <= t.sample;
        s_start_finish <= (t.flags & F_START) != 0;
        s_abort_finish <= (t.flags & F_ABORT) != 0;
        s_manual_open  <= (t.flags & F_OPEN) != 0;
        s_manual_close <= (t.flags & F_CLOSE) != 0;
        s_tare_ready   <= (t.flags & F_RDY) != 0;
        s_tare_busy    <= (t.flags & F_BUSY) != 0;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        // the predictor advances on every word, typed rows included
        predicted = hopper_step(t);
        expected_words.push_back(typed ? want : predicted);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_tolerance(input logic [TOL_BITS-1:0] value);
        tol_wr_en   <= 1'b1;
        tol_wr_data <= value;
        tol_model    = value;
        @(posedge aclk);
        tol_wr_en   <= 1'b0;
    endtask

    // one random phase: new tolerance, new idling mix, optional long hold-off
    task automatic run_phase(input logic [TOL_BITS-1:0] tol, input int s_pct,
                             input int r_pct, input bit squeeze);
        result_t unused;
        int      n;
        write_tolerance(tol);
        send_idle_pct   = s_pct;
        recv_stall_pct <= r_pct;
        for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (squeeze && n == 20)
                hold_seq <= hold_seq + 1;
            send_tick(random_tick(), 1'b0, unused);
        end
        drain_results();
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // result checker: each accepted word against the oldest expectation
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("word with nothing pending", 3'd1, 3'd0);
            end else begin
                want = expected_words.pop_front();
                if (m_valve_open !== want.valve)
                    report_mismatch("valve_open", m_valve_open, want.valve);
                if (m_tare_request !== want.tare_req)
                    report_mismatch("tare_request", m_tare_request, want.tare_req);
                if (m_finishing !== want.active)
                    report_mismatch("finishing", m_finishing, want.active);
                if (m_phase !== want.phase)
                    report_mismatch("phase", m_phase, want.phase);
                if (m_stable_empty !== want.stable)
                    report_mismatch("stable_empty", m_stable_empty, want.stable);
            end
            words_checked++;
        end
    end

    // watchdog on handshake progress
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // predictor matches the reset state of the block
        for (int i = 0; i < WINDOW_DEPTH; i++)
            win_model[i] = WINDOW_INIT;
        seq_phase   = PH_IDLE;
        seq_active  = 1'b0;
        valve_state = 1'b0;
        tol_model   = TOL_RESET;

        // directed table, tolerance at its reset value of 50
        row_exp(24'sd0, F_NONE, 1'b0, 1'b0, 1'b0, PH_IDLE, 1'b0);        // window still at -1000
        row_exp(24'sd0, F_START, 1'b1, 1'b0, 1'b1, PH_WAIT_EMPTY, 1'b0); // opening runs at once
        row_pred(24'sd50, F_NONE);                                      // upper band edge
        row_pred(-24'sd50, F_NONE);                                     // lower band edge
        row_pred(24'sd0, F_NONE);
        row_pred(24'sd1, F_NONE);
        row_pred(-24'sd1, F_NONE);
        row_pred(24'sd0, F_NONE);                                       // window full and quiet
        row_pred(24'sd25, F_NONE);                                      // tare asked, not taken
        row_pred(24'sd0, F_RDY);                                        // tare taken
        row_pred(24'sd0, F_BUSY);                                       // tare still busy
        row_pred(24'sd0, F_NONE);                                       // back to idle
        row_exp(24'sd8388607, F_START | F_ABORT, 1'b0, 1'b0, 1'b0, PH_IDLE, 1'b0); // abort wins
        row_exp(-24'sd8388608, F_OPEN | F_CLOSE, 1'b0, 1'b0, 1'b0, PH_IDLE, 1'b0); // close wins
        row_exp(-24'sd200, F_OPEN, 1'b1, 1'b0, 1'b0, PH_IDLE, 1'b0);    // manual open alone
        row_pred(24'sd51, F_CLOSE);                                     // just outside the band
        row_pred(24'sd0, F_START | F_CLOSE);                            // step reopens the valve
        row_pred(-24'sd51, F_START);                                    // start while running
        row_pred(24'sd0, F_ABORT | F_OPEN);                             // abort mid-wait
        row_exp(-24'sd1, F_ALL, 1'b0, 1'b0, 1'b0, PH_IDLE, 1'b0);       // every flag at once
        row_pred(24'sh555555, F_RDY | F_BUSY);
        row_pred(24'shAAAAAA, F_START);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_tick(directed_rows[i].t, directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        // tolerance, sender idle %, receiver stall %, long hold-off
        run_phase(TOL_RESET, 0, 0, 1'b0);
        run_phase('0, 75, 0, 1'b0);
        run_phase(TOL_MAX, 0, 75, 1'b0);
        run_phase(TOL_BITS'(200), 24, 24, 1'b0);
        run_phase(TOL_BITS'($urandom_range(0, 1000)), 0, 0, 1'b1);

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
